// File: hdl/sgr_pkg.sv
// Shared constants and types for the stream group reverser.
`timescale 1ns / 1ps

package sgr_pkg;

    localparam int DATA_W        = 32;
    localparam int GS_W          = 5;
    localparam int MAX_GROUP_DEF = 16;
    localparam logic [GS_W-1:0] GS_RESET = GS_W'(1);

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP_HEAD,
        OP_POP_TAIL
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REV,
        ST_FWD
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] head_val;
        logic [DATA_W-1:0] tail_val;
        logic              second_vld;
    } t_chain_stat;

endpackage

// File: hdl/sgr_in_if.sv
// Input and output stream interfaces of the stream group reverser.
`timescale 1ns / 1ps

interface sgr_in_if import sgr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] item_value;
    logic                     list_end;

    modport source (output valid, output item_value, output list_end, input ready);
    modport sink   (input valid, input item_value, input list_end, output ready);
endinterface

interface sgr_out_if import sgr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_value;
    logic                     burst_end;
    logic                     out_list_end;

    modport source (output valid, output out_value, output burst_end,
                    output out_list_end, input ready);
    modport sink   (input valid, input out_value, input burst_end,
                    input out_list_end, output ready);
endinterface

// File: hdl/stream_group_reverser.sv
// Top level of the stream group reverser.
// Words enter a row of MAX_GROUP cells, one word per cycle while the block is
// idle. When the held count reaches group_size (0 or 1 meaning one, values above
// MAX_GROUP meaning MAX_GROUP), the group is unloaded from the head of the row,
// newest first; when a list ends on a partial group, that remainder is unloaded
// from the tail, oldest first. Unloading moves one word per cycle into the
// output register whenever it is free (output stalls hold it), and input is held
// off meanwhile. The word after the last result of a group may enter while that
// result still waits in the output register. burst_end marks the last word of
// each unload, and out_list_end marks it too when the unload ends a list.
`timescale 1ns / 1ps

module stream_group_reverser import sgr_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [GS_W-1:0]  i_cfg_wdata,
    sgr_in_if.sink           i_in,
    sgr_out_if.source        o_out
);

    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int CMP_W = ((CNT_W > GS_W) ? CNT_W : GS_W) + 1;

    logic [GS_W-1:0]   r_group_size;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    t_state            r_state;
    t_state            n_state;
    logic              r_list_end;
    logic              n_list_end;

    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_value;
    logic              r_o_burst_end;
    logic              r_o_list_end;

    t_cell_op          w_op;
    t_chain_stat       w_stat;
    logic              w_accept;
    logic              w_out_free;
    logic              w_step;
    logic              w_last;
    logic [DATA_W-1:0] w_pop_val;
    logic [CMP_W-1:0]  w_n;
    logic [CMP_W-1:0]  w_k;
    logic [CMP_W-1:0]  w_gs;
    logic [CMP_W-1:0]  w_max;
    logic              w_close;

    sgr_chain #(
        .MAX_GROUP (MAX_GROUP)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_push_val (DATA_W'(i_in.item_value)),
        .o_stat     (w_stat)
    );

    assign w_gs    = CMP_W'(r_group_size);
    assign w_max   = CMP_W'(MAX_GROUP);
    assign w_k     = (r_group_size == '0) ? CMP_W'(1) : ((w_gs > w_max) ? w_max : w_gs);
    assign w_n     = CMP_W'(r_fill) + CMP_W'(1);
    assign w_close = (w_n >= w_k);

    assign w_out_free = !r_o_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_last     = !w_stat.second_vld;

    // next state
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_list_end = r_list_end;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (w_close) begin
                        n_state    = ST_REV;
                        n_fill     = '0;
                        n_list_end = i_in.list_end;
                    end else if (i_in.list_end) begin
                        n_state    = ST_FWD;
                        n_fill     = '0;
                        n_list_end = 1'b1;
                    end else begin
                        n_fill = CNT_W'(w_n);
                    end
                end
            end
            ST_REV, ST_FWD: begin
                if (w_out_free && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready = 1'b0;
        w_op       = OP_HOLD;
        w_step     = 1'b0;
        w_pop_val  = w_stat.head_val;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    w_op = OP_PUSH;
                end
            end
            ST_REV: begin
                w_step = w_out_free;
                if (w_out_free) begin
                    w_op = OP_POP_HEAD;
                end
            end
            ST_FWD: begin
                w_step    = w_out_free;
                w_pop_val = w_stat.tail_val;
                if (w_out_free) begin
                    w_op = OP_POP_TAIL;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GS_RESET;
            r_fill       <= '0;
            r_state      <= ST_IDLE;
            r_list_end   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_group_size <= i_cfg_wdata;
            end
            if (w_accept || r_state != ST_IDLE) begin
                r_fill     <= n_fill;
                r_list_end <= n_list_end;
            end
            r_state <= n_state;
            if (w_step) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_o_value     <= w_pop_val;
            r_o_burst_end <= w_last;
            r_o_list_end  <= w_last && r_list_end;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.out_value    = $signed(r_o_value);
    assign o_out.burst_end    = r_o_burst_end;
    assign o_out.out_list_end = r_o_list_end;

endmodule

// File: hdl/sgr_cell.sv
// One storage cell of the group chain: holds a word and its valid bit.
`timescale 1ns / 1ps

module sgr_cell import sgr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_op          i_op,
    input  logic [DATA_W-1:0] i_left_val,
    input  logic              i_left_vld,
    input  logic [DATA_W-1:0] i_right_val,
    input  logic              i_right_vld,
    output logic [DATA_W-1:0] o_val,
    output logic              o_vld,
    output logic [DATA_W-1:0] o_tail_val
);

    logic [DATA_W-1:0] r_val;
    logic              r_vld;
    logic [DATA_W-1:0] n_val;
    logic              n_vld;

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        unique case (i_op)
            OP_HOLD: begin
            end
            OP_PUSH: begin
                n_val = i_left_val;
                n_vld = i_left_vld;
            end
            OP_POP_HEAD: begin
                n_val = i_right_val;
                n_vld = i_right_vld;
            end
            OP_POP_TAIL: begin
                n_vld = r_vld & i_right_vld;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_val <= n_val;
    end

    assign o_val      = r_val;
    assign o_vld      = r_vld;
    // oldest word of the group: valid here, empty beyond
    assign o_tail_val = (r_vld && !i_right_vld) ? r_val : '0;

endmodule

// File: hdl/sgr_chain.sv
// Row of cells: newest word at the head, oldest at the tail.
`timescale 1ns / 1ps

module sgr_chain import sgr_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_op          i_op,
    input  logic [DATA_W-1:0] i_push_val,
    output t_chain_stat       o_stat
);

    logic [DATA_W-1:0] w_val  [MAX_GROUP];
    logic              w_vld  [MAX_GROUP];
    logic [DATA_W-1:0] w_tail [MAX_GROUP];
    logic [DATA_W-1:0] w_tail_or;

    genvar g;
    generate
        for (g = 0; g < MAX_GROUP; g++) begin : g_cell
            logic [DATA_W-1:0] w_left_val;
            logic              w_left_vld;
            logic [DATA_W-1:0] w_right_val;
            logic              w_right_vld;

            if (g == 0) begin : g_head
                assign w_left_val = i_push_val;
                assign w_left_vld = 1'b1;
            end else begin : g_mid
                assign w_left_val = w_val[g-1];
                assign w_left_vld = w_vld[g-1];
            end

            if (g == MAX_GROUP - 1) begin : g_end
                assign w_right_val = '0;
                assign w_right_vld = 1'b0;
            end else begin : g_inner
                assign w_right_val = w_val[g+1];
                assign w_right_vld = w_vld[g+1];
            end

            sgr_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_op        (i_op),
                .i_left_val  (w_left_val),
                .i_left_vld  (w_left_vld),
                .i_right_val (w_right_val),
                .i_right_vld (w_right_vld),
                .o_val       (w_val[g]),
                .o_vld       (w_vld[g]),
                .o_tail_val  (w_tail[g])
            );
        end
    endgenerate

    always_comb begin
        w_tail_or = '0;
        for (int i = 0; i < MAX_GROUP; i++) begin
            w_tail_or = w_tail_or | w_tail[i];
        end
    end

    assign o_stat.head_val   = w_val[0];
    assign o_stat.tail_val   = w_tail_or;
    assign o_stat.second_vld = w_vld[1];

endmodule

// File: sim/stream_group_reverser_tb.sv
// Testbench for stream_group_reverser: directed table, pressure phase, random lists.
`timescale 1ns / 1ps

module stream_group_reverser_tb;
    import sgr_pkg::*;

    localparam int MAX_GROUP  = MAX_GROUP_DEF;
    localparam int SETTLE     = 4 * MAX_GROUP + 8;
    localparam int LIMIT      = 200_000;
    localparam int RAND_WORDS = 200;
    localparam int LONG_HOLD  = 300;
    localparam int MAX_REPORT = 30;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     burst_end;
        logic                     list_end;
    } t_out_word;

    typedef enum logic {
        ROW_CFG,
        ROW_WORD
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [GS_W-1:0]          gsize;
        logic signed [DATA_W-1:0] value;
        logic                     list_end;
        logic                     typed;
        t_out_word                want;
    } t_row;

    localparam t_out_word NO_WANT = '{32'sd0, 1'b0, 1'b0};
    localparam int        NUM_DIR = 27;

    // typed rows are pass-through only: each word comes back alone as its own burst
    localparam t_row DIR_ROWS [NUM_DIR] = '{
        '{ROW_WORD, 5'd0,  32'h7FFF_FFFF, 1'b0, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
        '{ROW_WORD, 5'd0,  32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b1}},
        '{ROW_WORD, 5'd0,  32'h0000_0000, 1'b0, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{ROW_WORD, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1}},
        '{ROW_CFG,  5'd0,  32'h0,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h5555_5555, 1'b0, 1'b1, '{32'h5555_5555, 1'b1, 1'b0}},
        '{ROW_WORD, 5'd0,  32'hAAAA_AAAA, 1'b1, 1'b1, '{32'hAAAA_AAAA, 1'b1, 1'b1}},
        '{ROW_CFG,  5'd3,  32'h0,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h1,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h2,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h3,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h4,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h5,         1'b1, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h6,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h7,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h8,         1'b1, 1'b0, NO_WANT},
        '{ROW_CFG,  5'd8,  32'h0,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h9,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'hA,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'hB,         1'b0, 1'b0, NO_WANT},
        '{ROW_CFG,  5'd2,  32'h0,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'hC,         1'b0, 1'b0, NO_WANT},
        '{ROW_CFG,  5'd31, 32'h0,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'h8000_0000, 1'b1, 1'b0, NO_WANT},
        '{ROW_CFG,  5'd16, 32'h0,         1'b0, 1'b0, NO_WANT},
        '{ROW_WORD, 5'd0,  32'hD,         1'b1, 1'b0, NO_WANT}
    };

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [GS_W-1:0] i_cfg_wdata;

    sgr_in_if  in_if ();
    sgr_out_if out_if ();

    stream_group_reverser #(.MAX_GROUP(MAX_GROUP)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    logic [GS_W-1:0]          group_len;
    logic signed [DATA_W-1:0] group_buf [MAX_GROUP];
    int unsigned              held;
    t_out_word                pending_words [$];
    int unsigned              errors = 0;
    int unsigned              cycles = 0;

    logic      drv_typed;
    t_out_word drv_want;
    bit        tx_idle;
    bit        rx_idle;
    int        rx_hold;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic reorder_word(input logic signed [DATA_W-1:0] value, input logic le,
                                input logic typed, input t_out_word want);
        int unsigned k;
        int unsigned n;
        int unsigned i;
        t_out_word   w;
        if (group_len == 0) begin
            k = 1;
        end else if (group_len > MAX_GROUP) begin
            k = MAX_GROUP;
        end else begin
            k = group_len;
        end
        if (held >= MAX_GROUP) begin
            held = MAX_GROUP - 1;
        end
        group_buf[held] = value;
        held++;
        n = held;
        if (typed) begin
            pending_words.push_back(want);
        end
        if (n >= k || le) begin
            for (i = 0; i < n; i++) begin
                w.value     = (n >= k) ? group_buf[n - 1 - i] : group_buf[i];
                w.burst_end = (i == n - 1);
                w.list_end  = (i == n - 1) && le;
                if (!typed) begin
                    pending_words.push_back(w);
                end
            end
            held = 0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_word w;
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAIL stream_group_reverser");
            $finish;
        end else if (!i_rst_n) begin
            group_len = GS_RESET;
            held      = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pending_words.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORT) begin
                        $display("%0t: unexpected word: expected none, actual %h/%b/%b",
                                 $time, out_if.out_value, out_if.burst_end,
                                 out_if.out_list_end);
                    end
                end else begin
                    w = pending_words.pop_front();
                    if (out_if.out_value !== w.value) begin
                        errors++;
                        if (errors <= MAX_REPORT) begin
                            $display("%0t: out_value: expected %h, actual %h",
                                     $time, w.value, out_if.out_value);
                        end
                    end
                    if (out_if.burst_end !== w.burst_end) begin
                        errors++;
                        if (errors <= MAX_REPORT) begin
                            $display("%0t: burst_end: expected %b, actual %b",
                                     $time, w.burst_end, out_if.burst_end);
                        end
                    end
                    if (out_if.out_list_end !== w.list_end) begin
                        errors++;
                        if (errors <= MAX_REPORT) begin
                            $display("%0t: out_list_end: expected %b, actual %b",
                                     $time, w.list_end, out_if.out_list_end);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                group_len = i_cfg_wdata;
            end
            if (in_if.valid && in_if.ready) begin
                reorder_word(in_if.item_value, in_if.list_end, drv_typed, drv_want);
            end
        end
    end

    initial begin : result_side
        int gap;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = rx_idle ? $urandom_range(0, 14) : 0;
            if (rx_hold > 0 || gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (rx_hold + gap) @(negedge i_clk);
                rx_hold = 0;
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic offer_word(input logic signed [DATA_W-1:0] value, input logic le,
                              input logic typed, input t_out_word want);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.item_value <= value;
        in_if.list_end   <= le;
        drv_typed        <= typed;
        drv_want         <= want;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_group_len(input logic [GS_W-1:0] gsize);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= gsize;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int                       sent;
        int                       burst;
        int                       pick;
        logic [GS_W-1:0]          gsize;
        logic signed [DATA_W-1:0] v;
        logic                     le;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_if.valid      = 1'b0;
        in_if.item_value = '0;
        in_if.list_end   = 1'b0;
        drv_typed        = 1'b0;
        drv_want         = NO_WANT;
        tx_idle          = 1'b1;
        rx_idle          = 1'b1;
        rx_hold          = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_DIR; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                set_group_len(DIR_ROWS[r].gsize);
            end else begin
                offer_word(DIR_ROWS[r].value, DIR_ROWS[r].list_end,
                           DIR_ROWS[r].typed, DIR_ROWS[r].want);
            end
        end

        // back-to-back groups of up to MAX_GROUP words against a stalled output
        set_group_len(GS_W'(MAX_GROUP));
        tx_idle = 1'b0;
        rx_hold = LONG_HOLD;
        repeat (3 * MAX_GROUP) begin
            offer_word($urandom, $urandom_range(0, 15) == 0, 1'b0, NO_WANT);
        end
        wait_idle();

        sent = 0;
        while (sent < RAND_WORDS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: gsize = '0;
                1: gsize = GS_W'(1);
                2: gsize = GS_W'(MAX_GROUP);
                3: gsize = GS_W'($urandom_range(MAX_GROUP + 1, (1 << GS_W) - 1));
                default: gsize = GS_W'($urandom_range(2, 6));
            endcase
            set_group_len(gsize);
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            burst   = $urandom_range(6, 24);
            repeat (burst) begin
                case ($urandom_range(0, 9))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sd0;
                    3: v = -32'sd1;
                    default: v = $urandom;
                endcase
                le = $urandom_range(0, 6) == 0;
                offer_word(v, le, 1'b0, NO_WANT);
                sent++;
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("PASS stream_group_reverser");
        end else begin
            $display("FAIL stream_group_reverser");
        end
        $finish;
    end

endmodule
